// ===== sv/sras_pkg.sv =====
// ----------------------------------------------------------------------------
// sras_pkg
// Shared constants and types of the SPI register access slave.
// ----------------------------------------------------------------------------
package sras_pkg;

   localparam int STORE_DEPTH_DEF = 1024;
   localparam int MAX_BURST_DEF   = 16;

   localparam int ADDR_W  = 16;
   localparam int BYTE_W  = 8;
   localparam int BURST_W = 5;

   localparam logic [BYTE_W-1:0] CMD_WRITE = 8'h20;
   localparam logic [BYTE_W-1:0] IDLE_BYTE = 8'hff;

   // frame phase
   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_ADDR_HI = 2'd1;
   localparam logic [1:0] PH_ADDR_LO = 2'd2;
   localparam logic [1:0] PH_DATA    = 2'd3;

   // command kind
   localparam logic [1:0] KIND_NONE    = 2'd0;
   localparam logic [1:0] KIND_WRITE   = 2'd1;
   localparam logic [1:0] KIND_READ    = 2'd2;
   localparam logic [1:0] KIND_UNKNOWN = 2'd3;

   // per-beat control from the frame decoder to the store and result path
   typedef struct packed {
      logic              wr_en;
      logic              mem_read;
      logic              wrote;
      logic              fault;
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] data;
   } slot_ctl_type;

endpackage

// ===== sv/sras_req_if.sv =====
// ----------------------------------------------------------------------------
// sras_req_if
// Request channel: one MOSI byte per beat with its frame start mark.
// ----------------------------------------------------------------------------
interface sras_req_if;
   logic                            valid;
   logic                            ready;
   logic                            frame_start;
   logic [sras_pkg::BYTE_W-1:0]     mosi_byte;

   modport source (output valid, output frame_start, output mosi_byte, input ready);
   modport sink   (input valid, input frame_start, input mosi_byte, output ready);
endinterface

// ===== sv/sras_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sras_rsp_if
// Response channel: one MISO byte per beat with write and fault flags.
// ----------------------------------------------------------------------------
interface sras_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [sras_pkg::BYTE_W-1:0]     miso_byte;
   logic                            wrote;
   logic                            fault;

   modport source (output valid, output miso_byte, output wrote, output fault, input ready);
   modport sink   (input valid, input miso_byte, input wrote, input fault, output ready);
endinterface

// ===== sv/spi_register_access_slave.sv =====
// ----------------------------------------------------------------------------
// spi_register_access_slave
// Device side of a byte-wide SPI register bridge with a local byte store.
// ----------------------------------------------------------------------------
// One MOSI byte is taken per clock; its MISO byte passes through the s1
// stage, where the store's registered read completes, and then the output
// register, and the beat rate stays at one byte per clock as long as the
// response side keeps up. An output register parts the two channels, so a
// new byte is taken while a finished response waits. After reset the store
// is swept to zero, one entry per clock, while req_ch.ready is held low.
module spi_register_access_slave #(
   parameter int STORE_DEPTH = sras_pkg::STORE_DEPTH_DEF,
   parameter int MAX_BURST   = sras_pkg::MAX_BURST_DEF
) (
   input  logic        clock,
   input  logic        reset,
   sras_req_if.sink    req_ch,
   sras_rsp_if.source  rsp_ch
);

   sras_pkg::slot_ctl_type        ctl;
   logic [sras_pkg::BYTE_W-1:0]   rd_data;
   logic                          clear_busy;
   logic                          accept;
   logic                          s1_move;

   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_mem_ff;
   logic                          s1_wrote_ff;
   logic                          s1_fault_ff;

   logic                          o_valid_ff, o_valid_in;
   logic [sras_pkg::BYTE_W-1:0]   o_miso_ff;
   logic                          o_wrote_ff;
   logic                          o_fault_ff;

   assign s1_move      = s1_valid_ff & (~o_valid_ff | rsp_ch.ready);
   assign req_ch.ready = ~clear_busy & (~s1_valid_ff | s1_move);
   assign accept       = req_ch.valid & req_ch.ready;

   sras_frame_dec #(
      .STORE_DEPTH (STORE_DEPTH),
      .MAX_BURST   (MAX_BURST)
   ) u_dec (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .frame_start (req_ch.frame_start),
      .mosi_byte   (req_ch.mosi_byte),
      .ctl         (ctl)
   );

   sras_store #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .rd_data    (rd_data),
      .clear_busy (clear_busy)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      o_valid_in = o_valid_ff;
      if (s1_move) begin
         o_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         o_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         o_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         o_valid_ff  <= o_valid_in;
      end
   end

   // beat flags wait here while the store read completes
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mem_ff   <= ctl.mem_read;
         s1_wrote_ff <= ctl.wrote;
         s1_fault_ff <= ctl.fault;
      end
      if (s1_move) begin
         o_miso_ff  <= s1_mem_ff ? rd_data : sras_pkg::IDLE_BYTE;
         o_wrote_ff <= s1_wrote_ff;
         o_fault_ff <= s1_fault_ff;
      end
   end

   assign rsp_ch.valid     = o_valid_ff;
   assign rsp_ch.miso_byte = o_miso_ff;
   assign rsp_ch.wrote     = o_wrote_ff;
   assign rsp_ch.fault     = o_fault_ff;

endmodule

// ===== sv/sras_frame_dec.sv =====
// ----------------------------------------------------------------------------
// sras_frame_dec
// Frame decoder: command, address and burst tracking for each accepted byte.
// ----------------------------------------------------------------------------
module sras_frame_dec #(
   parameter int STORE_DEPTH = sras_pkg::STORE_DEPTH_DEF,
   parameter int MAX_BURST   = sras_pkg::MAX_BURST_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          frame_start,
   input  logic [sras_pkg::BYTE_W-1:0]   mosi_byte,
   output sras_pkg::slot_ctl_type        ctl
);

   logic [1:0]                     phase_ff, phase_in;
   logic [1:0]                     kind_ff, kind_in;
   logic [sras_pkg::ADDR_W-1:0]    addr_ff, addr_in;
   logic [sras_pkg::BURST_W-1:0]   left_ff, left_in;
   logic [sras_pkg::BURST_W-1:0]   burst_raw;
   logic [sras_pkg::BURST_W-1:0]   burst_len;
   logic                           in_range;
   sras_pkg::slot_ctl_type         slot;

   assign burst_raw = {1'b0, mosi_byte[3:0]} + sras_pkg::BURST_W'(1);
   assign burst_len = (burst_raw > sras_pkg::BURST_W'(MAX_BURST))
                      ? sras_pkg::BURST_W'(MAX_BURST) : burst_raw;
   assign in_range  = {1'b0, addr_ff} < (sras_pkg::ADDR_W+1)'(STORE_DEPTH);

   always_comb begin
      phase_in = phase_ff;
      kind_in  = kind_ff;
      addr_in  = addr_ff;
      left_in  = left_ff;
      slot     = '0;
      slot.addr = addr_ff;
      slot.data = mosi_byte;
      if (frame_start) begin
         phase_in = sras_pkg::PH_ADDR_HI;
         addr_in  = '0;
         left_in  = '0;
         if (mosi_byte == sras_pkg::CMD_WRITE) begin
            kind_in = sras_pkg::KIND_WRITE;
         end else if (mosi_byte[7:4] == 4'h0) begin
            kind_in = sras_pkg::KIND_READ;
            left_in = burst_len;
         end else begin
            kind_in    = sras_pkg::KIND_UNKNOWN;
            slot.fault = 1'b1;
         end
      end else if (phase_ff == sras_pkg::PH_IDLE) begin
         // no frame open
      end else if (kind_ff == sras_pkg::KIND_UNKNOWN) begin
         slot.fault = 1'b1;
         if (phase_ff != sras_pkg::PH_DATA) begin
            phase_in = phase_ff + 2'd1;
         end
      end else begin
         case (phase_ff)
            sras_pkg::PH_ADDR_HI: begin
               addr_in  = {mosi_byte, 8'h00};
               phase_in = sras_pkg::PH_ADDR_LO;
            end
            sras_pkg::PH_ADDR_LO: begin
               addr_in  = addr_ff | {8'h00, mosi_byte};
               phase_in = sras_pkg::PH_DATA;
            end
            default: begin
               if (kind_ff == sras_pkg::KIND_WRITE) begin
                  if (in_range) begin
                     slot.wr_en = 1'b1;
                     slot.wrote = 1'b1;
                  end else begin
                     slot.fault = 1'b1;
                  end
                  addr_in = addr_ff + sras_pkg::ADDR_W'(1);
               end else if (kind_ff == sras_pkg::KIND_READ) begin
                  if (left_ff != '0) begin
                     if (in_range) begin
                        slot.mem_read = 1'b1;
                     end else begin
                        slot.fault = 1'b1;
                     end
                     addr_in = addr_ff + sras_pkg::ADDR_W'(1);
                     left_in = left_ff - sras_pkg::BURST_W'(1);
                  end
               end
            end
         endcase
      end
   end

   // store strobes only fire on an accepted beat
   always_comb begin
      ctl          = slot;
      ctl.wr_en    = slot.wr_en & accept;
      ctl.mem_read = slot.mem_read & accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sras_pkg::PH_IDLE;
         kind_ff  <= sras_pkg::KIND_NONE;
         addr_ff  <= '0;
         left_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         addr_ff  <= addr_in;
         left_ff  <= left_in;
      end
   end

endmodule

// ===== sv/sras_store.sv =====
// ----------------------------------------------------------------------------
// sras_store
// Register store: single-port byte memory with a clearing sweep after reset.
// ----------------------------------------------------------------------------
module sras_store #(
   parameter int STORE_DEPTH = sras_pkg::STORE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sras_pkg::slot_ctl_type        ctl,
   output logic [sras_pkg::BYTE_W-1:0]   rd_data,
   output logic                          clear_busy
);

   localparam int AW = $clog2(STORE_DEPTH);

   logic [sras_pkg::BYTE_W-1:0] mem [STORE_DEPTH];
   logic [sras_pkg::BYTE_W-1:0] rd_data_ff;
   logic                        clr_busy_ff;
   logic [AW-1:0]               clr_idx_ff;
   logic [AW-1:0]               idx;

   assign idx        = ctl.addr[AW-1:0];
   assign rd_data    = rd_data_ff;
   assign clear_busy = clr_busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_idx_ff <= clr_idx_ff + AW'(1);
         if (clr_idx_ff == AW'(STORE_DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_idx_ff] <= '0;
      end else if (ctl.wr_en) begin
         mem[idx] <= ctl.data;
      end
      if (ctl.mem_read) begin
         rd_data_ff <= mem[idx];
      end
   end

endmodule

// ===== dv/spi_register_access_slave_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spi_register_access_slave_test
// Drives SPI register frames (writes, read bursts, unknown commands, cut
// frames and stray bytes) beat by beat with random gaps on both channels,
// predicts every MISO beat from a local copy of the byte store and checks
// each response beat field by field in order.
// ----------------------------------------------------------------------------
module spi_register_access_slave_test;

   localparam int RANDOM_BEATS = 1750;
   localparam int LONG_HOLD    = 400;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int MAX_PRINTS   = 40;

   // read command: upper nibble zero, low nibble is burst length minus one
   localparam logic [3:0] READ_OP = 4'h0;

   typedef struct packed {
      logic [sras_pkg::BYTE_W-1:0] miso;
      logic                        wrote;
      logic                        fault;
   } miso_beat_type;

   class miso_predictor;
      logic [1:0]                   phase;
      logic [1:0]                   kind;
      logic [sras_pkg::ADDR_W-1:0]  addr;
      logic [sras_pkg::BURST_W-1:0] burst_left;
      logic [sras_pkg::BYTE_W-1:0]  store [sras_pkg::STORE_DEPTH_DEF];
      miso_beat_type                miso_due[$];
      int mismatches, beats, frames, stores, loads, faults;

      function new();
         phase      = sras_pkg::PH_IDLE;
         kind       = sras_pkg::KIND_NONE;
         addr       = '0;
         burst_left = '0;
         foreach (store[i]) store[i] = '0;
         mismatches = 0;
         beats      = 0;
         frames     = 0;
         stores     = 0;
         loads      = 0;
         faults     = 0;
      endfunction

      function void take_mosi(logic start, logic [sras_pkg::BYTE_W-1:0] b);
         miso_beat_type due;
         int n;
         due.miso  = sras_pkg::IDLE_BYTE;
         due.wrote = 1'b0;
         due.fault = 1'b0;
         if (start) begin
            frames++;
            phase      = sras_pkg::PH_ADDR_HI;
            addr       = '0;
            burst_left = '0;
            if (b == sras_pkg::CMD_WRITE) begin
               kind = sras_pkg::KIND_WRITE;
            end else if (b[7:4] == READ_OP) begin
               n = int'(b[3:0]) + 1;
               if (n > sras_pkg::MAX_BURST_DEF) n = sras_pkg::MAX_BURST_DEF;
               kind       = sras_pkg::KIND_READ;
               burst_left = sras_pkg::BURST_W'(n);
            end else begin
               kind      = sras_pkg::KIND_UNKNOWN;
               due.fault = 1'b1;
            end
         end else if (phase == sras_pkg::PH_IDLE) begin
            // no frame open yet, byte is ignored
         end else if (kind == sras_pkg::KIND_UNKNOWN) begin
            due.fault = 1'b1;
            if (phase != sras_pkg::PH_DATA) phase = phase + 2'd1;
         end else if (phase == sras_pkg::PH_ADDR_HI) begin
            addr  = {b, 8'h00};
            phase = sras_pkg::PH_ADDR_LO;
         end else if (phase == sras_pkg::PH_ADDR_LO) begin
            addr[7:0] = b;
            phase     = sras_pkg::PH_DATA;
         end else if (kind == sras_pkg::KIND_WRITE) begin
            if (addr < sras_pkg::STORE_DEPTH_DEF) begin
               store[addr] = b;
               due.wrote   = 1'b1;
               stores++;
            end else begin
               due.fault = 1'b1;
            end
            addr = addr + 1'b1;
         end else if (kind == sras_pkg::KIND_READ && burst_left != 0) begin
            if (addr < sras_pkg::STORE_DEPTH_DEF) begin
               due.miso = store[addr];
               loads++;
            end else begin
               due.fault = 1'b1;
            end
            addr       = addr + 1'b1;
            burst_left = burst_left - 1'b1;
         end
         if (due.fault) faults++;
         miso_due.push_back(due);
      endfunction

      task report_mismatch(string what, int got, int want);
         mismatches++;
         if (mismatches <= MAX_PRINTS)
            $display("%0t: %0s mismatch on response beat %0d: got %02h, expected %02h",
                     $realtime, what, beats, got, want);
      endtask

      task check_miso(miso_beat_type got);
         miso_beat_type want;
         if (miso_due.size() == 0) begin
            report_mismatch("unexpected beat", got, 0);
         end else begin
            want = miso_due.pop_front();
            if (got.miso !== want.miso) report_mismatch("miso_byte", got.miso, want.miso);
            if (got.wrote !== want.wrote) report_mismatch("wrote", got.wrote, want.wrote);
            if (got.fault !== want.fault) report_mismatch("fault", got.fault, want.fault);
         end
         beats++;
      endtask
   endclass

   logic clock;
   logic reset;

   sras_req_if req_ch ();
   sras_rsp_if rsp_ch ();

   spi_register_access_slave uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   miso_predictor               pred;
   logic [sras_pkg::BYTE_W-1:0] frame_q[$];
   int                          mosi_sent;
   bit                          tx_rush;
   bit                          rx_rush;
   bit                          long_hold;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int draw_gap();
      return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 17);
   endfunction

   // one request beat; called and returns at a rising edge
   task send_byte(input logic start, input logic [sras_pkg::BYTE_W-1:0] b);
      int gap;
      gap = tx_rush ? 0 : draw_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.frame_start <= start;
      req_ch.mosi_byte   <= b;
      do @(posedge clock); while (!req_ch.ready);
      pred.take_mosi(start, b);
      mosi_sent++;
   endtask

   task send_frame();
      foreach (frame_q[i]) send_byte(i == 0, frame_q[i]);
      frame_q.delete();
   endtask

   // mostly a small hot window so reads hit earlier writes, plus range edges
   function automatic logic [sras_pkg::ADDR_W-1:0] pick_addr();
      int p;
      p = $urandom_range(0, 99);
      if (p < 60) return sras_pkg::ADDR_W'($urandom_range(0, 47));
      if (p < 80)
         return sras_pkg::ADDR_W'($urandom_range(0, sras_pkg::STORE_DEPTH_DEF - 1));
      if (p < 88)
         return sras_pkg::ADDR_W'($urandom_range(sras_pkg::STORE_DEPTH_DEF - 8,
                                                 sras_pkg::STORE_DEPTH_DEF + 7));
      if (p < 94) return sras_pkg::ADDR_W'($urandom_range(65528, 65535));
      return sras_pkg::ADDR_W'($urandom_range(0, 65535));
   endfunction

   task open_frame(input logic [sras_pkg::BYTE_W-1:0] cmd,
                   input logic [sras_pkg::ADDR_W-1:0] a);
      frame_q.delete();
      frame_q.push_back(cmd);
      frame_q.push_back(a[15:8]);
      frame_q.push_back(a[7:0]);
   endtask

   task build_random_frame();
      int r, n;
      logic [sras_pkg::BYTE_W-1:0] cmd;
      r = $urandom_range(0, 92);
      if (r < 45) begin
         open_frame(sras_pkg::CMD_WRITE, pick_addr());
         n = $urandom_range(0, 8);
      end else if (r < 85) begin
         cmd = {READ_OP, 4'($urandom_range(0, 15))};
         open_frame(cmd, pick_addr());
         n = int'(cmd[3:0]) + 1 + $urandom_range(0, 2);
      end else begin
         do cmd = 8'($urandom_range(16, 255)); while (cmd == sras_pkg::CMD_WRITE);
         frame_q.delete();
         frame_q.push_back(cmd);
         n = $urandom_range(0, 5);
      end
      repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
      // cut some frames short so a new frame mark lands mid-frame
      if ($urandom_range(0, 11) == 0) begin
         n = $urandom_range(1, frame_q.size());
         while (frame_q.size() > n) void'(frame_q.pop_back());
      end
   endtask

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timed out after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
   end

   initial begin : miso_sink
      int gap;
      int taken;
      miso_beat_type got;
      taken = 0;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (long_hold) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold = 1'b0;
         end
         gap = rx_rush ? 0 : draw_gap();
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         got.miso  = rsp_ch.miso_byte;
         got.wrote = rsp_ch.wrote;
         got.fault = rsp_ch.fault;
         pred.check_miso(got);
         taken++;
         if (taken % 29 == 0) rx_rush = ($urandom_range(0, 2) == 0);
      end
   end

   initial begin : mosi_source
      int rand_start;
      pred      = new();
      mosi_sent = 0;
      tx_rush   = 1'b0;
      rx_rush   = 1'b0;
      long_hold = 1'b0;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.frame_start <= 1'b0;
      req_ch.mosi_byte   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // stray bytes before any frame
      send_byte(1'b0, 8'h00);
      send_byte(1'b0, 8'hff);
      // write two bytes starting at address zero
      frame_q = '{sras_pkg::CMD_WRITE, 8'h00, 8'h00, 8'hff, 8'h00};
      send_frame();
      // read burst of two, then one slot past the end of the burst
      frame_q = '{{READ_OP, 4'd1}, 8'h00, 8'h00, 8'h5a, 8'ha5, 8'h3c};
      send_frame();
      // unknown command
      frame_q = '{8'hff, 8'h12, 8'h34};
      send_frame();
      // write across the top of the store
      frame_q = '{sras_pkg::CMD_WRITE, 8'h03, 8'hff, 8'h5a, 8'hc3};
      send_frame();
      // read from the top of the address space (a fault), wrapping to zero
      frame_q = '{{READ_OP, 4'd1}, 8'hff, 8'hff, 8'h00, 8'h00};
      send_frame();
      // longest burst, cut off after the high address byte
      frame_q = '{{READ_OP, 4'hf}, 8'h00};
      send_frame();

      // receiver stalls for a long stretch while beats keep coming
      long_hold  = 1'b1;
      rand_start = mosi_sent;
      while (mosi_sent - rand_start < RANDOM_BEATS) begin
         tx_rush = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 99) < 7) begin
            repeat ($urandom_range(1, 4)) send_byte(1'b0, 8'($urandom_range(0, 255)));
         end else begin
            build_random_frame();
            send_frame();
         end
      end
      req_ch.valid <= 1'b0;

      while (pred.miso_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d beats in %0d frames: %0d store writes, %0d store reads",
               pred.beats, pred.frames, pred.stores, pred.loads);
      $display("%0d faults flagged, %0d field mismatches", pred.faults, pred.mismatches);
      if (pred.mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
